/* hw/rtl/mskr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mskr_pkg: shared types, constants and saturating helpers
// Frame snapshot, result bundle and Q32.32 saturation arithmetic.
// ----------------------------------------------------------------------------
package mskr_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  // register map of the configuration port
  localparam logic [0:0] RegTempScale = 1'b0;
  localparam logic [0:0] RegDof       = 1'b1;

  // sums of one closed frame
  typedef struct packed {
    logic [62:0]      mass;
    logic [63:0]      kin;
    logic [2:0][63:0] mom;
    logic [2:0][63:0] wpos;
    logic [2:0][63:0] ang;
  } mskr_frame_t;

  typedef struct packed {
    logic [63:0]      temperature;
    logic [2:0][63:0] mom;
    logic [2:0][63:0] com;
    logic [2:0][63:0] ang;
    logic [62:0]      mass;
    logic             err;
  } mskr_result_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) sat_add = a[63] ? SMIN : SMAX;
    else sat_add = r;
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) sat_sub = a[63] ? SMIN : SMAX;
    else sat_sub = r;
  endfunction

  // sign and magnitude back to two's complement, clamped
  function automatic logic [63:0] from_sm(input logic neg, input logic [63:0] mag);
    logic [63:0] r;
    if (!neg) r = (mag > SMAX) ? SMAX : mag;
    else r = (mag > SMIN) ? SMIN : (64'd0 - mag);
    from_sm = r;
  endfunction

  // join the two 32x24 halves of x*m, shift right 16, saturate
  function automatic logic [63:0] umul_combine(input logic [55:0] hi, input logic [55:0] lo);
    logic [64:0] sum;
    sum = {1'b0, hi[47:0], 16'b0} + {25'b0, lo[55:16]};
    if (hi[55:48] != 8'd0 || sum[64]) umul_combine = '1;
    else umul_combine = sum[63:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/md_system_kinetics_reduction_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md_system_kinetics_reduction_core: kinetic temperature and momentum reduction
// Streams atoms, closes a frame on the last atom and reports temperature,
// momentum, centre of mass and angular momentum about the centre of mass.
// ----------------------------------------------------------------------------
// Atoms are taken one beat per clock into a five-stage product pipeline that
// feeds saturating Q32.32 accumulators; the atom flagged last closes the
// frame, its sums move into a two-entry frame queue and the accumulators
// start over with the next beat. A finishing sequencer then works the queued
// frame through one shared 32x32 multiplier (seven 64x64 products) and one
// bit-serial divider (one quotient for temperature and three for the centre
// of mass). Intake runs at one atom per clock as long as a frame slot is
// free; with two frames waiting for the sequencer, ready drops until one is
// taken. Write configuration only while no frame is pending.
// ----------------------------------------------------------------------------
module md_system_kinetics_reduction_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // atom stream
  input  logic               atom_valid_i,
  output logic               atom_ready_o,
  input  logic [23:0]        atom_mass_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic               last_atom_i,
  // result stream
  output logic               result_valid_o,
  input  logic               result_ready_i,
  output logic signed [63:0] temperature_o,
  output logic signed [63:0] momentum_x_o,
  output logic signed [63:0] momentum_y_o,
  output logic signed [63:0] momentum_z_o,
  output logic signed [63:0] center_x_o,
  output logic signed [63:0] center_y_o,
  output logic signed [63:0] center_z_o,
  output logic signed [63:0] angular_x_o,
  output logic signed [63:0] angular_y_o,
  output logic signed [63:0] angular_z_o,
  output logic [62:0]        mass_total_o,
  output logic               divide_error_o
);
  import mskr_pkg::*;

  logic [31:0]  temp_scale_q, temp_scale_d;
  logic [17:0]  dof_q, dof_d;

  logic         frame_push, frame_pop, queue_empty;
  mskr_frame_t  frame_in, frame_head;
  mskr_result_t result;

  // configuration registers; writes to unknown indexes drop
  always_comb begin
    temp_scale_d = temp_scale_q;
    dof_d        = dof_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegTempScale: temp_scale_d = cfg_data_i;
        RegDof:       dof_d        = cfg_data_i[17:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_scale_q <= 32'd65536;
      dof_q        <= 18'd3;
    end else begin
      temp_scale_q <= temp_scale_d;
      dof_q        <= dof_d;
    end
  end

  // intake and accumulation
  mskr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .atom_valid_i (atom_valid_i),
    .atom_ready_o (atom_ready_o),
    .atom_mass_i  (atom_mass_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .vel_z_i      (vel_z_i),
    .last_atom_i  (last_atom_i),
    .frame_pop_i  (frame_pop),
    .frame_push_o (frame_push),
    .frame_o      (frame_in)
  );

  // closed frames wait here
  mskr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (frame_push),
    .push_data_i (frame_in),
    .pop_i       (frame_pop),
    .empty_o     (queue_empty),
    .head_o      (frame_head)
  );

  // finishing sequencer with its output register
  mskr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_avail_i  (!queue_empty),
    .frame_i        (frame_head),
    .frame_pop_o    (frame_pop),
    .temp_scale_i   (temp_scale_q),
    .dof_i          (dof_q),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .result_o       (result)
  );

  assign temperature_o  = result.temperature;
  assign momentum_x_o   = result.mom[0];
  assign momentum_y_o   = result.mom[1];
  assign momentum_z_o   = result.mom[2];
  assign center_x_o     = result.com[0];
  assign center_y_o     = result.com[1];
  assign center_z_o     = result.com[2];
  assign angular_x_o    = result.ang[0];
  assign angular_y_o    = result.ang[1];
  assign angular_z_o    = result.ang[2];
  assign mass_total_o   = result.mass;
  assign divide_error_o = result.err;

endmodule
`default_nettype wire

/* hw/rtl/mskr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mskr_front: atom intake, product pipeline and frame accumulators
// Five stages of per-atom products feed the saturating sums; a last atom
// pushes the closed frame into the queue and clears the sums.
// ----------------------------------------------------------------------------
module mskr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  atom_valid_i,
  output logic                  atom_ready_o,
  input  logic [23:0]           atom_mass_i,
  input  logic signed [31:0]    pos_x_i,
  input  logic signed [31:0]    pos_y_i,
  input  logic signed [31:0]    pos_z_i,
  input  logic signed [31:0]    vel_x_i,
  input  logic signed [31:0]    vel_y_i,
  input  logic signed [31:0]    vel_z_i,
  input  logic                  last_atom_i,
  input  logic                  frame_pop_i,
  output logic                  frame_push_o,
  output mskr_pkg::mskr_frame_t frame_o
);
  import mskr_pkg::*;

  logic accept;
  logic [QueueCntW-1:0] credit_q, credit_d;

  // stage 1: captured atom
  logic               s1_valid_q, s1_last_q;
  logic [23:0]        s1_mass_q;
  logic signed [31:0] s1_pos_q [3];
  logic signed [31:0] s1_vel_q [3];
  // stage 2: raw products
  logic               s2_valid_q, s2_last_q;
  logic [23:0]        s2_mass_q;
  logic signed [56:0] s2_mv_q [3], s2_mv_d [3];
  logic signed [56:0] s2_mr_q [3], s2_mr_d [3];
  logic [63:0]        s2_vsq_q [3], s2_vsq_d [3];
  logic signed [63:0] s2_rv_q [6], s2_rv_d [6];
  // stage 3: speed sum and cross terms
  logic               s3_valid_q, s3_last_q;
  logic [23:0]        s3_mass_q;
  logic signed [56:0] s3_mv_q [3], s3_mr_q [3];
  logic [63:0]        s3_s_q, s3_s_d;
  logic [63:0]        s3_cmag_q [3], s3_cmag_d [3];
  logic               s3_cneg_q [3], s3_cneg_d [3];
  // stage 4: 32x24 halves
  logic               s4_valid_q, s4_last_q;
  logic [23:0]        s4_mass_q;
  logic signed [56:0] s4_mv_q [3], s4_mr_q [3];
  logic               s4_cneg_q [3];
  logic [55:0]        s4_shi_q, s4_slo_q;
  logic [55:0]        s4_chi_q [3], s4_clo_q [3];
  // stage 5: per-atom terms
  logic               s5_valid_q, s5_last_q;
  logic [23:0]        s5_mass_q;
  logic signed [56:0] s5_mv_q [3], s5_mr_q [3];
  logic [63:0]        s5_kin_q, s5_ang_q [3];
  // accumulators
  logic [62:0]        mass_q, mass_d;
  logic [63:0]        kin_q, kin_d;
  logic [63:0]        mom_q [3], mom_d [3];
  logic [63:0]        wpos_q [3], wpos_d [3];
  logic [63:0]        ang_q [3], ang_d [3];

  assign atom_ready_o = (credit_q != '0);
  assign accept       = atom_valid_i && atom_ready_o;

  always_comb begin
    credit_d = credit_q;
    if (accept && last_atom_i) credit_d = credit_d - QueueCntW'(1);
    if (frame_pop_i) credit_d = credit_d + QueueCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q   <= QueueCntW'(QueueDepth);
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      credit_q   <= credit_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q   <= last_atom_i;
    s1_mass_q   <= atom_mass_i;
    s1_pos_q[0] <= pos_x_i;
    s1_pos_q[1] <= pos_y_i;
    s1_pos_q[2] <= pos_z_i;
    s1_vel_q[0] <= vel_x_i;
    s1_vel_q[1] <= vel_y_i;
    s1_vel_q[2] <= vel_z_i;
  end

  // stage 2
  always_comb begin
    logic [31:0] vmag;
    for (int i = 0; i < 3; i++) begin
      vmag        = s1_vel_q[i][31] ? (32'd0 - s1_vel_q[i]) : s1_vel_q[i];
      s2_vsq_d[i] = 64'(vmag) * 64'(vmag);
      s2_mv_d[i]  = $signed({1'b0, s1_mass_q}) * s1_vel_q[i];
      s2_mr_d[i]  = $signed({1'b0, s1_mass_q}) * s1_pos_q[i];
    end
    s2_rv_d[0] = s1_pos_q[1] * s1_vel_q[2];
    s2_rv_d[1] = s1_pos_q[2] * s1_vel_q[1];
    s2_rv_d[2] = s1_pos_q[2] * s1_vel_q[0];
    s2_rv_d[3] = s1_pos_q[0] * s1_vel_q[2];
    s2_rv_d[4] = s1_pos_q[0] * s1_vel_q[1];
    s2_rv_d[5] = s1_pos_q[1] * s1_vel_q[0];
  end

  always_ff @(posedge clk_i) begin
    s2_last_q <= s1_last_q;
    s2_mass_q <= s1_mass_q;
    s2_mv_q   <= s2_mv_d;
    s2_mr_q   <= s2_mr_d;
    s2_vsq_q  <= s2_vsq_d;
    s2_rv_q   <= s2_rv_d;
  end

  // stage 3
  always_comb begin
    logic [63:0] c;
    s3_s_d = s2_vsq_q[0] + s2_vsq_q[1] + s2_vsq_q[2];
    for (int i = 0; i < 3; i++) begin
      c            = sat_sub(s2_rv_q[2*i], s2_rv_q[2*i+1]);
      s3_cneg_d[i] = c[63];
      s3_cmag_d[i] = c[63] ? (64'd0 - c) : c;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_last_q <= s2_last_q;
    s3_mass_q <= s2_mass_q;
    s3_mv_q   <= s2_mv_q;
    s3_mr_q   <= s2_mr_q;
    s3_s_q    <= s3_s_d;
    s3_cmag_q <= s3_cmag_d;
    s3_cneg_q <= s3_cneg_d;
  end

  // stage 4
  always_ff @(posedge clk_i) begin
    s4_last_q <= s3_last_q;
    s4_mass_q <= s3_mass_q;
    s4_mv_q   <= s3_mv_q;
    s4_mr_q   <= s3_mr_q;
    s4_cneg_q <= s3_cneg_q;
    s4_shi_q  <= 56'(s3_s_q[63:32]) * 56'(s3_mass_q);
    s4_slo_q  <= 56'(s3_s_q[31:0]) * 56'(s3_mass_q);
    for (int i = 0; i < 3; i++) begin
      s4_chi_q[i] <= 56'(s3_cmag_q[i][63:32]) * 56'(s3_mass_q);
      s4_clo_q[i] <= 56'(s3_cmag_q[i][31:0]) * 56'(s3_mass_q);
    end
  end

  // stage 5
  always_ff @(posedge clk_i) begin
    s5_last_q <= s4_last_q;
    s5_mass_q <= s4_mass_q;
    s5_mv_q   <= s4_mv_q;
    s5_mr_q   <= s4_mr_q;
    s5_kin_q  <= umul_combine(s4_shi_q, s4_slo_q);
    for (int i = 0; i < 3; i++) begin
      s5_ang_q[i] <= from_sm(s4_cneg_q[i], umul_combine(s4_chi_q[i], s4_clo_q[i]));
    end
  end

  // accumulate
  always_comb begin
    logic [63:0] mass_t;
    logic [64:0] kin_t;
    mass_t = {1'b0, mass_q} + {24'd0, s5_mass_q, 16'd0};
    mass_d = (mass_t > SMAX) ? SMAX[62:0] : mass_t[62:0];
    kin_t  = {1'b0, kin_q} + {1'b0, s5_kin_q};
    kin_d  = kin_t[64] ? '1 : kin_t[63:0];
    for (int i = 0; i < 3; i++) begin
      mom_d[i]  = sat_add(mom_q[i], {{7{s5_mv_q[i][56]}}, s5_mv_q[i]});
      wpos_d[i] = sat_add(wpos_q[i], {{7{s5_mr_q[i][56]}}, s5_mr_q[i]});
      ang_d[i]  = sat_add(ang_q[i], s5_ang_q[i]);
    end
  end

  assign frame_push_o = s5_valid_q && s5_last_q;

  always_comb begin
    frame_o.mass = mass_d;
    frame_o.kin  = kin_d;
    for (int i = 0; i < 3; i++) begin
      frame_o.mom[i]  = mom_d[i];
      frame_o.wpos[i] = wpos_d[i];
      frame_o.ang[i]  = ang_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= '0;
      kin_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        mom_q[i]  <= '0;
        wpos_q[i] <= '0;
        ang_q[i]  <= '0;
      end
    end else if (s5_valid_q) begin
      if (s5_last_q) begin
        mass_q <= '0;
        kin_q  <= '0;
        for (int i = 0; i < 3; i++) begin
          mom_q[i]  <= '0;
          wpos_q[i] <= '0;
          ang_q[i]  <= '0;
        end
      end else begin
        mass_q <= mass_d;
        kin_q  <= kin_d;
        mom_q  <= mom_d;
        wpos_q <= wpos_d;
        ang_q  <= ang_d;
      end
    end
  end

  // a frame slot is either free credit, in flight, or queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= QueueCntW'(QueueDepth))
    else $error("frame credit above queue depth");

endmodule
`default_nettype wire

/* hw/rtl/mskr_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mskr_fifo: short queue of closed frames
// Decouples the atom intake from the finishing sequencer.
// ----------------------------------------------------------------------------
module mskr_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mskr_pkg::mskr_frame_t push_data_i,
  input  logic                  pop_i,
  output logic                  empty_o,
  output mskr_pkg::mskr_frame_t head_o
);
  import mskr_pkg::*;

  mskr_frame_t          entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 full;

  assign full    = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  function automatic logic [QueuePtrW-1:0] ptr_next(input logic [QueuePtrW-1:0] p);
    if (p == QueuePtrW'(QueueDepth - 1)) ptr_next = '0;
    else ptr_next = p + QueuePtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i) rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) count_q <= count_q + QueueCntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - QueueCntW'(1);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full)
    else $error("frame queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("frame queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + QueueCntW'(1))
    else $error("frame queue count did not advance on push");

endmodule
`default_nettype wire

/* hw/rtl/mskr_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mskr_back: frame finishing sequencer
// One shared 32x32 multiplier and one radix-2 divider turn a frame's sums
// into temperature, centre of mass and angular momentum.
// ----------------------------------------------------------------------------
module mskr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   frame_avail_i,
  input  mskr_pkg::mskr_frame_t  frame_i,
  output logic                   frame_pop_o,
  input  logic [31:0]            temp_scale_i,
  input  logic [17:0]            dof_i,
  output logic                   result_valid_o,
  input  logic                   result_ready_i,
  output mskr_pkg::mskr_result_t result_o
);
  import mskr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  localparam int unsigned DivSteps = 96;
  localparam logic [2:0]  LastProd = 3'd6;
  localparam logic [2:0]  LastPart = 3'd4;
  localparam logic [1:0]  LastDiv  = 2'd3;

  state_e       state_q, state_d;
  mskr_frame_t  frame_q, frame_d;
  logic [2:0]   pidx_q, pidx_d;
  logic [2:0]   mstep_q, mstep_d;
  logic [63:0]  mul_q, mul_d;
  logic [1:0]   mshift_q, mshift_d;
  logic [127:0] acc_q, acc_d;
  logic [127:0] p1_q, p1_d;
  logic [1:0]   didx_q, didx_d;
  logic [6:0]   dcnt_q, dcnt_d;
  logic [95:0]  num_q, num_d;
  logic [63:0]  rem_q, rem_d;
  logic [95:0]  quo_q, quo_d;
  logic [63:0]  den_q, den_d;
  logic         dneg_q, dneg_d;
  logic [63:0]  temp_q, temp_d;
  logic [63:0]  com_q [3], com_d [3];
  logic [63:0]  ang_q [3], ang_d [3];
  mskr_result_t res_q, res_d;
  logic         res_valid_q, res_valid_d;

  // shared multiplier operands
  logic [63:0]  op_a, op_b, mag_a, mag_b;
  logic         prod_neg;
  logic [127:0] prod;
  // divider step
  logic [64:0]  r_sh;
  logic         r_ge;

  function automatic logic [63:0] cross_sat(input logic [127:0] p1, input logic [127:0] p2);
    logic [127:0] d;
    d = p1 - p2;
    if (p1[127] != p2[127] && d[127] != p1[127]) cross_sat = p1[127] ? SMIN : SMAX;
    else if (d[127:95] != '0 && d[127:95] != '1) cross_sat = d[127] ? SMIN : SMAX;
    else cross_sat = d[95:32];
  endfunction

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (pidx_q)
      3'd0: begin op_a = frame_q.kin;    op_b = {32'd0, temp_scale_i}; end
      3'd1: begin op_a = com_q[1];       op_b = frame_q.mom[2]; end
      3'd2: begin op_a = com_q[2];       op_b = frame_q.mom[1]; end
      3'd3: begin op_a = com_q[2];       op_b = frame_q.mom[0]; end
      3'd4: begin op_a = com_q[0];       op_b = frame_q.mom[2]; end
      3'd5: begin op_a = com_q[0];       op_b = frame_q.mom[1]; end
      3'd6: begin op_a = com_q[1];       op_b = frame_q.mom[0]; end
      default: begin op_a = '0;          op_b = '0; end
    endcase
    // the temperature product is unsigned, the cross products are signed
    if (pidx_q == 3'd0) begin
      mag_a    = op_a;
      mag_b    = op_b;
      prod_neg = 1'b0;
    end else begin
      mag_a    = op_a[63] ? (64'd0 - op_a) : op_a;
      mag_b    = op_b[63] ? (64'd0 - op_b) : op_b;
      prod_neg = op_a[63] ^ op_b[63];
    end
  end

  always_comb begin
    r_sh = {rem_q, num_q[95]};
    r_ge = (r_sh >= {1'b0, den_q});
  end

  always_comb begin
    logic [64:0] r_new;
    logic [63:0] qmag;
    logic [1:0]  axis;
    state_d     = state_q;
    frame_d     = frame_q;
    pidx_d      = pidx_q;
    mstep_d     = mstep_q;
    mul_d       = mul_q;
    mshift_d    = mshift_q;
    acc_d       = acc_q;
    p1_d        = p1_q;
    didx_d      = didx_q;
    dcnt_d      = dcnt_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    den_d       = den_q;
    dneg_d      = dneg_q;
    temp_d      = temp_q;
    com_d       = com_q;
    ang_d       = ang_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    frame_pop_o = 1'b0;
    prod        = '0;
    r_new       = '0;
    qmag        = '0;
    axis        = '0;

    if (result_valid_o && result_ready_i) res_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (frame_avail_i) begin
          frame_pop_o = 1'b1;
          frame_d     = frame_i;
          pidx_d      = '0;
          mstep_d     = '0;
          state_d     = ST_MUL;
        end
      end

      ST_MUL: begin
        // issue one 32x32 partial a cycle, add it in the cycle after
        if (mstep_q != LastPart) begin
          mul_d    = 64'(mstep_q[0] ? mag_a[63:32] : mag_a[31:0])
                   * 64'(mstep_q[1] ? mag_b[63:32] : mag_b[31:0]);
          mshift_d = 2'(mstep_q[0]) + 2'(mstep_q[1]);
        end
        if (mstep_q == '0) acc_d = '0;
        else acc_d = acc_q + (128'(mul_q) << {mshift_q, 5'd0});
        mstep_d = mstep_q + 3'd1;
        if (mstep_q == LastPart) begin
          prod    = prod_neg ? (128'd0 - acc_d) : acc_d;
          mstep_d = '0;
          pidx_d  = pidx_q + 3'd1;
          if (pidx_q == '0) begin
            num_d   = acc_d[95:0];
            den_d   = {46'd0, dof_i};
            dneg_d  = 1'b0;
            rem_d   = '0;
            dcnt_d  = '0;
            didx_d  = '0;
            state_d = ST_DIV;
          end else if (pidx_q[0]) begin
            p1_d = prod;
          end else begin
            axis        = pidx_q[2:1] - 2'd1;
            ang_d[axis] = sat_sub(frame_q.ang[axis], cross_sat(p1_q, prod));
            if (pidx_q == LastProd) state_d = ST_OUT;
          end
        end
      end

      ST_DIV: begin
        r_new  = r_ge ? (r_sh - {1'b0, den_q}) : r_sh;
        rem_d  = r_new[63:0];
        quo_d  = {quo_q[94:0], r_ge};
        num_d  = {num_q[94:0], 1'b0};
        dcnt_d = dcnt_q + 7'd1;
        if (dcnt_q == 7'(DivSteps - 1)) begin
          if (didx_q == '0) begin
            if (dof_i == '0) temp_d = '0;
            else if (quo_d[95:79] != '0) temp_d = SMAX;
            else temp_d = {1'b0, quo_d[78:16]};
          end else begin
            qmag = (quo_d[95:64] != '0) ? '1 : quo_d[63:0];
            com_d[didx_q - 2'd1] = (frame_q.mass == '0) ? '0 : from_sm(dneg_q, qmag);
          end
          if (didx_q == LastDiv) begin
            pidx_d  = 3'd1;
            mstep_d = '0;
            state_d = ST_MUL;
          end else begin
            // next centre-of-mass axis: |sum m*r| * 2^32 over the mass
            dneg_d = frame_q.wpos[didx_q][63];
            num_d  = {frame_q.wpos[didx_q][63] ? (64'd0 - frame_q.wpos[didx_q])
                                               : frame_q.wpos[didx_q], 32'd0};
            den_d  = {1'b0, frame_q.mass};
            rem_d  = '0;
            dcnt_d = '0;
            didx_d = didx_q + 2'd1;
          end
        end
      end

      ST_OUT: begin
        if (!result_valid_o || result_ready_i) begin
          res_d.temperature = temp_q;
          for (int i = 0; i < 3; i++) begin
            res_d.mom[i] = frame_q.mom[i];
            res_d.com[i] = com_q[i];
            res_d.ang[i] = ang_q[i];
          end
          res_d.mass  = frame_q.mass;
          res_d.err   = (frame_q.mass == '0) || (dof_i == '0);
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      pidx_q      <= '0;
      mstep_q     <= '0;
      didx_q      <= '0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      pidx_q      <= pidx_d;
      mstep_q     <= mstep_d;
      didx_q      <= didx_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q  <= frame_d;
    mul_q    <= mul_d;
    mshift_q <= mshift_d;
    acc_q    <= acc_d;
    p1_q     <= p1_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    den_q    <= den_d;
    dneg_q   <= dneg_d;
    temp_q   <= temp_d;
    com_q    <= com_d;
    ang_q    <= ang_d;
    res_q    <= res_d;
  end

endmodule
`default_nettype wire

/* test/md_system_kinetics_reduction_core_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md_system_kinetics_reduction_core_test: self-checking bench for the core
// Streams atom frames through the core under several register settings and
// handshake idling patterns. A bit-true predictor computes each frame result,
// and the monitor compares the core's results field by field, in order.
// ----------------------------------------------------------------------------
module md_system_kinetics_reduction_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 2000000;
  // the wait covers a whole frame's work in the sequencer, with room to spare
  localparam int unsigned DrainCycles = 700;

  localparam logic signed [129:0] WideMax = 130'sd9223372036854775807;
  localparam logic signed [129:0] WideMin = -WideMax - 130'sd1;
  localparam logic [63:0] PosMax = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [23:0]      mass;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic             last;
  } atom_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic atom_valid_i = 1'b0;
  logic atom_ready_o;
  logic [23:0] atom_mass_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic last_atom_i = 1'b0;
  logic result_valid_o;
  logic result_ready_i = 1'b0;
  logic signed [63:0] temperature_o;
  logic signed [63:0] momentum_x_o, momentum_y_o, momentum_z_o;
  logic signed [63:0] center_x_o, center_y_o, center_z_o;
  logic signed [63:0] angular_x_o, angular_y_o, angular_z_o;
  logic [62:0] mass_total_o;
  logic divide_error_o;

  md_system_kinetics_reduction_core dut (.*);

  always #2 clk_i = ~clk_i;

  // pending atoms, expected frame results, and the mirrored core state
  atom_t atom_queue[$];
  mskr_pkg::mskr_result_t frame_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  logic [63:0] mass_acc, kin_acc;
  logic [2:0][63:0] mom_acc, wpos_acc, ang_acc;
  logic [31:0] scale_reg = 32'd65536;
  logic [17:0] dof_reg = 18'd3;

  function automatic logic [63:0] clamp_s64(input logic signed [129:0] x);
    if (x > WideMax) return PosMax;
    if (x < WideMin) return ~PosMax;
    return x[63:0];
  endfunction

  function automatic logic signed [129:0] widen(input logic [63:0] x);
    logic signed [129:0] w;
    w = 130'($signed(x));
    return w;
  endfunction

  // floor(a * m / 2^16), pinned at 2^64-1
  function automatic logic [63:0] mass_scale(input logic [63:0] a, input logic [23:0] m);
    logic [127:0] p;
    p = 128'(a);
    p = (p * m) >> 16;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  // (a*b - c*d) >> 32 with floor, saturated
  function automatic logic [63:0] cross_shift(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] c, input logic [63:0] d);
    logic signed [129:0] x;
    x = widen(a) * widen(b) - widen(c) * widen(d);
    return clamp_s64(x >>> 32);
  endfunction

  function automatic void clear_sums();
    mass_acc = '0;
    kin_acc = '0;
    mom_acc = '0;
    wpos_acc = '0;
    ang_acc = '0;
  endfunction

  // fold one accepted atom into the sums; queue the frame result on the last one
  function automatic void absorb_atom(input atom_t a);
    logic signed [129:0] r[3], v[3], mw, c, mag, wq, num;
    logic [64:0] sum65;
    logic [63:0] sq, term, den;
    logic [127:0] tp, qq;
    logic [129:0] prod;
    logic [2:0][63:0] com;
    mskr_pkg::mskr_result_t res;
    int j, k;
    mw = {106'd0, a.mass};
    for (int i = 0; i < 3; i++) begin
      r[i] = 130'($signed(a.pos[i]));
      v[i] = 130'($signed(a.vel[i]));
    end
    sum65 = {1'b0, mass_acc} + ({41'd0, a.mass} << 16);
    mass_acc = (sum65 > {1'b0, PosMax}) ? PosMax : sum65[63:0];
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      prod = v[i] * v[i];
      sq = sq + prod[63:0];
      mom_acc[i] = clamp_s64(widen(mom_acc[i]) + v[i] * mw);
      wpos_acc[i] = clamp_s64(widen(wpos_acc[i]) + r[i] * mw);
    end
    sum65 = {1'b0, kin_acc} + mass_scale(sq, a.mass);
    kin_acc = sum65[64] ? '1 : sum65[63:0];
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      c = widen(clamp_s64(r[j] * v[k] - r[k] * v[j]));
      mag = (c < 0) ? -c : c;
      term = mass_scale(mag[63:0], a.mass);
      wq = {66'd0, term};
      term = clamp_s64((c < 0) ? -wq : wq);
      ang_acc[i] = clamp_s64(widen(ang_acc[i]) + widen(term));
    end
    if (!a.last) return;

    if (dof_reg == 0) res.temperature = '0;
    else begin
      tp = 128'(kin_acc);
      tp = (tp * scale_reg) / dof_reg;
      tp = tp >> 16;
      res.temperature = (tp > PosMax) ? PosMax : tp[63:0];
    end
    den = mass_acc;
    for (int i = 0; i < 3; i++) begin
      if (den == 0) com[i] = '0;
      else begin
        num = widen(wpos_acc[i]);
        mag = (num < 0) ? -num : num;
        qq = 128'(mag[63:0]);
        qq = (qq << 32) / den;
        wq = {2'b0, qq};
        com[i] = clamp_s64((num < 0) ? -wq : wq);
      end
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      res.mom[i] = mom_acc[i];
      res.com[i] = com[i];
      res.ang[i] = clamp_s64(widen(ang_acc[i]) -
                             widen(cross_shift(com[j], mom_acc[k], com[k], mom_acc[j])));
    end
    res.mass = mass_acc[62:0];
    res.err = (mass_acc == 0) || (dof_reg == 0);
    frame_results.push_back(res);
    clear_sums();
  endfunction

  initial clear_sums();

  // ---------------------------------------------------------------------------
  // Driver: advance to the next atom only when the current beat is taken or
  // nothing is on the bus; a random draw may hold the bus idle instead.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    atom_t a;
    if (!rst_ni) begin
      atom_valid_i <= 1'b0;
    end else if (!atom_valid_i || atom_ready_o) begin
      if (atom_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        a = atom_queue.pop_front();
        atom_mass_i <= a.mass;
        pos_x_i <= a.pos[0];
        pos_y_i <= a.pos[1];
        pos_z_i <= a.pos[2];
        vel_x_i <= a.vel[0];
        vel_y_i <= a.vel[1];
        vel_z_i <= a.vel[2];
        last_atom_i <= a.last;
        atom_valid_i <= 1'b1;
      end else begin
        atom_valid_i <= 1'b0;
      end
    end
  end

  // Receiver backpressure: stall the result channel at the phase's rate.
  always @(posedge clk_i) begin
    result_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted atom beat, and compare every accepted
  // result beat with the oldest prediction still waiting.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    atom_t a;
    mskr_pkg::mskr_result_t want;
    if (rst_ni && atom_valid_i && atom_ready_o) begin
      a.mass = atom_mass_i;
      a.pos = {pos_z_i, pos_y_i, pos_x_i};
      a.vel = {vel_z_i, vel_y_i, vel_x_i};
      a.last = last_atom_i;
      absorb_atom(a);
    end
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (frame_results.size() == 0) begin
        $error("result beat with no frame result pending");
        mismatches++;
      end else begin
        want = frame_results.pop_front();
        check_field("temperature", want.temperature, temperature_o);
        check_field("momentum_x", want.mom[0], momentum_x_o);
        check_field("momentum_y", want.mom[1], momentum_y_o);
        check_field("momentum_z", want.mom[2], momentum_z_o);
        check_field("center_x", want.com[0], center_x_o);
        check_field("center_y", want.com[1], center_y_o);
        check_field("center_z", want.com[2], center_z_o);
        check_field("angular_x", want.ang[0], angular_x_o);
        check_field("angular_y", want.ang[1], angular_y_o);
        check_field("angular_z", want.ang[2], angular_z_o);
        check_field("mass_total", {1'b0, want.mass}, {1'b0, mass_total_o});
        check_field("divide_error", {63'd0, want.err}, {63'd0, divide_error_o});
      end
    end
  end

  // Watchdog: fail the run once it exceeds the cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_mass();
    case ($urandom_range(7))
      0: return 24'h0;
      1: return 24'hFF_FFFF;
      2, 3: return 24'($urandom_range(1, 24'h02_0000));
      default: return 24'($urandom_range(24'hFF_FFFF));
    endcase
  endfunction

  task automatic push_atom(input logic [23:0] mass, input logic [95:0] pos,
                           input logic [95:0] vel, input logic last);
    atom_t a;
    a.mass = mass;
    a.pos = pos;
    a.vel = vel;
    a.last = last;
    atom_queue.push_back(a);
  endtask

  // one well-formed frame with random content; some frames carry no mass
  task automatic push_frame(input int n, input bit massless);
    for (int i = 0; i < n; i++)
      push_atom(massless ? 24'h0 : pick_mass(),
                {pick_coord(), pick_coord(), pick_coord()},
                {pick_coord(), pick_coord(), pick_coord()}, i == n - 1);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    if (idx == mskr_pkg::RegTempScale) scale_reg = value;
    else dof_reg = value[17:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold until every atom is taken and every frame result has come back
  task automatic drain();
    while (atom_queue.size() > 0 || atom_valid_i || frame_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] scale, input logic [17:0] dof,
                           input int unsigned idle, input int unsigned stall);
    int n, sent;
    drain();
    write_reg(mskr_pkg::RegTempScale, scale);
    write_reg(mskr_pkg::RegDof, {14'd0, dof});
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < 48) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      push_frame(n, $urandom_range(7) == 0);
      sent += n;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames under the reset register values, no idling
    push_atom(24'h0, '0, '0, 1'b1);
    push_atom(24'hFF_FFFF, {3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}, 1'b1);
    push_atom(24'hFF_FFFF, {3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, 1'b1);
    push_atom(24'hFF_FFFF, {3{32'h8000_0000}}, {3{32'h8000_0000}}, 1'b1);
    push_atom(24'hFF_FFFF, {32'h0, 32'h8000_0000, 32'h7FFF_FFFF},
              {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0);
    push_atom(24'hFF_FFFF, {32'h7FFF_FFFF, 32'h0, 32'h8000_0000},
              {32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0);
    push_atom(24'hFF_FFFF, {32'h8000_0000, 32'h7FFF_FFFF, 32'h0},
              {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b1);
    push_atom(24'h00_0001, {32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000},
              {32'hFFFF_8000, 32'h0002_0000, 32'h0000_0001}, 1'b1);
    push_atom(24'h0, {3{32'h1234_5678}}, {3{32'hFEDC_BA98}}, 1'b0);
    push_atom(24'h0, {3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}, 1'b1);
    push_atom(24'h01_0000, {3{32'h0001_0000}}, {32'h0, 32'h0, 32'h0001_0000}, 1'b0);
    push_atom(24'h01_0000, {3{32'hFFFF_0000}}, {32'h0, 32'h0001_0000, 32'h0}, 1'b1);
    push_atom(24'hAA_AAAA, {3{32'h5555_5555}}, {3{32'hAAAA_AAAA}}, 1'b0);
    push_atom(24'h55_5555, {3{32'hAAAA_AAAA}}, {3{32'h5555_5555}}, 1'b1);

    // sweep register settings, extremes included, across idling patterns
    run_phase(32'hFFFF_FFFF, 18'd1, 61, 0);
    run_phase(32'h0, 18'd0, 0, 61);
    run_phase($urandom, 18'h3FFFF, 32, 32);
    run_phase($urandom, 18'($urandom_range(1, 18'h3FFFF)), 0, 0);
    run_phase(32'd1, 18'd3, 61, 0);
    run_phase(32'hFFFF_FFFF, 18'h3FFFF, 32, 32);
    run_phase(32'd65536, 18'd0, 0, 61);
    drain();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
